// ===== hdl/metp_pkg.sv =====
// ----------------------------------------------------------------------------
// metp_pkg
// Shared types and constants for the escape-time pixel evaluator: word
// widths, register indexes, register reset values and the control and
// status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package metp_pkg;

    // Word widths
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ITER_W     = 16;
    localparam int PAL_W      = 10;
    localparam int COLOUR_W   = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_X_START   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_X_STEP    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_START   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_Y_STEP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_INIT_RE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_INIT_IM = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIM  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_PAL_SIZE  = 3'd7;

    // Register reset values (Q4.28 view of the plane)
    localparam coord_t             RST_X_START   = -32'sd536870912;
    localparam coord_t             RST_X_STEP    = 32'sd671679;
    localparam coord_t             RST_Y_START   = -32'sd268435456;
    localparam coord_t             RST_Y_STEP    = 32'sd672359;
    localparam coord_t             RST_Z_INIT_RE = 32'sd0;
    localparam coord_t             RST_Z_INIT_IM = 32'sd0;
    localparam logic [ITER_W-1:0]  RST_ITER_LIM  = 16'd768;
    localparam logic [PAL_W-1:0]   RST_PAL_SIZE  = 10'd768;

    // Saturation bounds for a coordinate
    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});

    // Colour ramp break points
    localparam logic [PAL_W-1:0]    RED_BASE   = 10'd512;
    localparam logic [PAL_W-1:0]    GREEN_BASE = 10'd256;
    localparam logic [PAL_W-1:0]    GREEN_TOP  = 10'd511;
    localparam logic [PAL_W-1:0]    BLUE_TOP   = 10'd255;
    localparam logic [COLOUR_W-1:0] COLOUR_MAX = 8'd255;

    // Configuration register set
    typedef struct packed {
        coord_t             x_start;
        coord_t             x_step;
        coord_t             y_start;
        coord_t             y_step;
        coord_t             z_init_re;
        coord_t             z_init_im;
        logic [ITER_W-1:0]  iteration_limit;
        logic [PAL_W-1:0]   palette_size;
    } cfg_t;

    // Sequencer to datapath commands
    typedef struct packed {
        logic start;    // form c products, reset z, count and index
        logic set_c;    // add start offsets, saturate c
        logic mul;      // register the three z products
        logic step;     // advance z, count and palette index
        logic capture;  // load the result word
    } dp_cmd_t;

    // Datapath to sequencer status
    typedef struct packed {
        logic at_limit; // count has reached the iteration limit
        logic escape;   // |z|^2 >= 4 for the registered products
    } dp_status_t;

endpackage

// ===== hdl/metp_cfg.sv =====
// ----------------------------------------------------------------------------
// metp_cfg
// Configuration register file. One write per cycle, no read-back.
// ----------------------------------------------------------------------------
module metp_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [metp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [metp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output metp_pkg::cfg_t                      cfg
);
    import metp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_X_START:   cfg_next.x_start         = coord_t'(cfg_wdata);
                REG_X_STEP:    cfg_next.x_step          = coord_t'(cfg_wdata);
                REG_Y_START:   cfg_next.y_start         = coord_t'(cfg_wdata);
                REG_Y_STEP:    cfg_next.y_step          = coord_t'(cfg_wdata);
                REG_Z_INIT_RE: cfg_next.z_init_re       = coord_t'(cfg_wdata);
                REG_Z_INIT_IM: cfg_next.z_init_im       = coord_t'(cfg_wdata);
                REG_ITER_LIM:  cfg_next.iteration_limit = cfg_wdata[ITER_W-1:0];
                REG_PAL_SIZE:  cfg_next.palette_size    = cfg_wdata[PAL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_start         <= RST_X_START;
            cfg_reg.x_step          <= RST_X_STEP;
            cfg_reg.y_start         <= RST_Y_START;
            cfg_reg.y_step          <= RST_Y_STEP;
            cfg_reg.z_init_re       <= RST_Z_INIT_RE;
            cfg_reg.z_init_im       <= RST_Z_INIT_IM;
            cfg_reg.iteration_limit <= RST_ITER_LIM;
            cfg_reg.palette_size    <= RST_PAL_SIZE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/metp_ctrl.sv =====
// ----------------------------------------------------------------------------
// metp_ctrl
// Sequencer: takes a pixel word, forms c, then alternates a multiply
// state and a test-and-update state until escape or the limit, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module metp_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  metp_pkg::dp_status_t    status,
    output metp_pkg::dp_cmd_t       cmd
);
    import metp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CSUM = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_TEST = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Output register can take a word this cycle
    assign out_free = !out_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_CSUM;
                end
            end
            ST_CSUM: begin
                cmd.set_c  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (status.at_limit || status.escape) begin
                    if (out_free) begin
                        cmd.capture = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        state_next  = ST_HOLD;
                    end
                end else begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result word valid flag
    always_comb begin
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

// ===== hdl/metp_dp.sv =====
// ----------------------------------------------------------------------------
// metp_dp
// Datapath: c generation, the z^2 + c recurrence with three
// 32x32 multipliers, the escape test, iteration and palette counters and
// the result register with the colour ramp.
// ----------------------------------------------------------------------------
module metp_dp #(
    parameter int FRAC_BITS        = 28,
    parameter int PIXEL_INDEX_BITS = 12,
    parameter int PALETTE_DEPTH    = 768
) (
    input  logic                                aclk,
    input  logic [PIXEL_INDEX_BITS-1:0]         pixel_column,
    input  logic [PIXEL_INDEX_BITS-1:0]         pixel_row,
    input  metp_pkg::cfg_t                      cfg,
    input  metp_pkg::dp_cmd_t                   cmd,
    output metp_pkg::dp_status_t                status,
    output logic [metp_pkg::ITER_W-1:0]         iteration_count,
    output logic                                escaped,
    output logic [metp_pkg::PAL_W-1:0]          palette_index,
    output logic [metp_pkg::COLOUR_W-1:0]       red,
    output logic [metp_pkg::COLOUR_W-1:0]       green,
    output logic [metp_pkg::COLOUR_W-1:0]       blue
);
    import metp_pkg::*;

    localparam int CPROD_W = PIXEL_INDEX_BITS + 1 + COORD_W;
    localparam int SAT_W   = PROD_W + 2;
    localparam int PSIZE_W = ($clog2(PALETTE_DEPTH + 1) > PAL_W) ?
                             $clog2(PALETTE_DEPTH + 1) : PAL_W;
    localparam logic [PSIZE_W-1:0] PSIZE_MAX  = PSIZE_W'(PALETTE_DEPTH);
    localparam logic [PROD_W-1:0]  ESC_BOUND  = PROD_W'(4) << FRAC_BITS;

    // Clamp a wide two's complement sum into a coordinate
    function automatic coord_t sat_coord(input logic [SAT_W-1:0] v);
        coord_t res;
        if (&v[SAT_W-1:COORD_W-1] || ~|v[SAT_W-1:COORD_W-1]) begin
            res = coord_t'(v[COORD_W-1:0]);
        end else if (v[SAT_W-1]) begin
            res = COORD_MIN;
        end else begin
            res = COORD_MAX;
        end
        return res;
    endfunction

    logic signed [PIXEL_INDEX_BITS:0] col_s;
    logic signed [PIXEL_INDEX_BITS:0] row_s;
    logic signed [CPROD_W-1:0]        cprod_re_reg;
    logic signed [CPROD_W-1:0]        cprod_im_reg;
    coord_t                           cr_reg;
    coord_t                           ci_reg;
    coord_t                           zr_reg;
    coord_t                           zi_reg;
    logic signed [PROD_W-1:0]         rr_reg;
    logic signed [PROD_W-1:0]         ii_reg;
    logic signed [PROD_W-1:0]         ri_reg;
    logic [ITER_W-1:0]                count_reg;
    logic [PAL_W-1:0]                 idx_reg;
    logic [PAL_W-1:0]                 idx_next;

    logic [SAT_W-1:0]                 cr_sum;
    logic [SAT_W-1:0]                 ci_sum;
    logic signed [PROD_W-1:0]         diff;
    logic signed [PROD_W-1:0]         diff_sh;
    logic signed [PROD_W-1:0]         cross_sh;
    logic [SAT_W-1:0]                 zr_sum;
    logic [SAT_W-1:0]                 zi_sum;
    logic [PROD_W-1:0]                mag;
    logic [PSIZE_W-1:0]               psize;
    logic [PSIZE_W-1:0]               idx_inc;
    logic                             esc;
    logic [PAL_W-1:0]                 idx_out;

    logic [ITER_W-1:0]                count_out_reg;
    logic                             esc_out_reg;
    logic [PAL_W-1:0]                 idx_out_reg;
    logic [COLOUR_W-1:0]              red_reg;
    logic [COLOUR_W-1:0]              green_reg;
    logic [COLOUR_W-1:0]              blue_reg;
    logic [COLOUR_W-1:0]              red_next;
    logic [COLOUR_W-1:0]              green_next;
    logic [COLOUR_W-1:0]              blue_next;

    assign col_s = $signed({1'b0, pixel_column});
    assign row_s = $signed({1'b0, pixel_row});

    // c = start + index * step, saturated
    assign cr_sum = {{(SAT_W-CPROD_W){cprod_re_reg[CPROD_W-1]}}, cprod_re_reg}
                  + {{(SAT_W-COORD_W){cfg.x_start[COORD_W-1]}}, cfg.x_start};
    assign ci_sum = {{(SAT_W-CPROD_W){cprod_im_reg[CPROD_W-1]}}, cprod_im_reg}
                  + {{(SAT_W-COORD_W){cfg.y_start[COORD_W-1]}}, cfg.y_start};

    // z update: floor shifts, add c, saturate
    assign diff     = rr_reg - ii_reg;
    assign diff_sh  = diff >>> FRAC_BITS;
    assign cross_sh = ri_reg >>> (FRAC_BITS - 1);
    assign zr_sum   = {{(SAT_W-PROD_W){diff_sh[PROD_W-1]}}, diff_sh}
                    + {{(SAT_W-COORD_W){cr_reg[COORD_W-1]}}, cr_reg};
    assign zi_sum   = {{(SAT_W-PROD_W){cross_sh[PROD_W-1]}}, cross_sh}
                    + {{(SAT_W-COORD_W){ci_reg[COORD_W-1]}}, ci_reg};

    // Escape test on the exact squared magnitude
    assign mag             = rr_reg + ii_reg;
    assign status.escape   = (mag >> FRAC_BITS) >= ESC_BOUND;
    assign status.at_limit = count_reg >= cfg.iteration_limit;

    // Effective palette size and wrapping index
    always_comb begin
        if (cfg.palette_size == '0) begin
            psize = PSIZE_W'(1);
        end else if (PSIZE_W'(cfg.palette_size) > PSIZE_MAX) begin
            psize = PSIZE_MAX;
        end else begin
            psize = PSIZE_W'(cfg.palette_size);
        end
        idx_inc  = PSIZE_W'(idx_reg) + PSIZE_W'(1);
        idx_next = (idx_inc >= psize) ? '0 : idx_inc[PAL_W-1:0];
    end

    // Colour ramp; inside points are black
    assign esc     = !status.at_limit;
    assign idx_out = esc ? idx_reg : '0;
    always_comb begin
        red_next   = (idx_out > RED_BASE) ? COLOUR_W'(idx_out - RED_BASE) : '0;
        if (idx_out < GREEN_BASE) begin
            green_next = '0;
        end else if (idx_out > GREEN_TOP) begin
            green_next = COLOUR_MAX;
        end else begin
            green_next = COLOUR_W'(idx_out - GREEN_BASE);
        end
        blue_next  = (idx_out > BLUE_TOP) ? COLOUR_MAX : COLOUR_W'(idx_out);
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cprod_re_reg <= CPROD_W'(col_s * cfg.x_step);
            cprod_im_reg <= CPROD_W'(row_s * cfg.y_step);
            zr_reg       <= cfg.z_init_re;
            zi_reg       <= cfg.z_init_im;
            count_reg    <= '0;
            idx_reg      <= '0;
        end
        if (cmd.set_c) begin
            cr_reg <= sat_coord(cr_sum);
            ci_reg <= sat_coord(ci_sum);
        end
        if (cmd.mul) begin
            rr_reg <= PROD_W'(zr_reg * zr_reg);
            ii_reg <= PROD_W'(zi_reg * zi_reg);
            ri_reg <= PROD_W'(zr_reg * zi_reg);
        end
        if (cmd.step) begin
            zr_reg    <= sat_coord(zr_sum);
            zi_reg    <= sat_coord(zi_sum);
            count_reg <= count_reg + ITER_W'(1);
            idx_reg   <= idx_next;
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            count_out_reg <= count_reg;
            esc_out_reg   <= esc;
            idx_out_reg   <= idx_out;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
        end
    end

    assign iteration_count = count_out_reg;
    assign escaped         = esc_out_reg;
    assign palette_index   = idx_out_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;

endmodule

// ===== hdl/mandelbrot_escape_time_pixel.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel of the Mandelbrot set.
// ----------------------------------------------------------------------------
// One pixel word at a time: c is formed from the pixel column and row, then
// z = z^2 + c is iterated in two steps per iteration (one to register the
// three 32x32 products, one for the escape test and the saturating update)
// until escape or the iteration limit, which resets to 768. The result
// sits in an output register; the next pixel is taken while it waits, and
// the block only stalls if a second result is ready before the first one is
// taken. Registers are written through cfg_we/cfg_addr/cfg_wdata and must
// only change while no pixel is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel #(
    parameter int FRAC_BITS        = 28,
    parameter int PIXEL_INDEX_BITS = 12,
    parameter int PALETTE_DEPTH    = 768
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [metp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [metp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // pixel words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [PIXEL_INDEX_BITS-1:0]         s_pixel_column,
    input  logic [PIXEL_INDEX_BITS-1:0]         s_pixel_row,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [metp_pkg::ITER_W-1:0]         m_iteration_count,
    output logic                                m_escaped,
    output logic [metp_pkg::PAL_W-1:0]          m_palette_index,
    output logic [metp_pkg::COLOUR_W-1:0]       m_red,
    output logic [metp_pkg::COLOUR_W-1:0]       m_green,
    output logic [metp_pkg::COLOUR_W-1:0]       m_blue
);
    import metp_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    metp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    metp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    metp_dp #(
        .FRAC_BITS        (FRAC_BITS),
        .PIXEL_INDEX_BITS (PIXEL_INDEX_BITS),
        .PALETTE_DEPTH    (PALETTE_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .pixel_column    (s_pixel_column),
        .pixel_row       (s_pixel_row),
        .cfg             (cfg),
        .cmd             (cmd),
        .status          (status),
        .iteration_count (m_iteration_count),
        .escaped         (m_escaped),
        .palette_index   (m_palette_index),
        .red             (m_red),
        .green           (m_green),
        .blue            (m_blue)
    );

    // One pixel in flight: no second word straight after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("pixel word taken while another is in flight");

    // Points inside the set come out black with index zero
    a_inside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_escaped |->
            m_palette_index == '0 && m_red == '0 && m_green == '0 && m_blue == '0)
        else $error("inside point with non-zero colour");

    // A result is only produced while the sequencer is busy with a pixel
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid ##1 m_valid |-> $past(!s_ready))
        else $error("result word appeared without a pixel in flight");

endmodule

// ===== tb/escape_time_checker.sv =====
// ----------------------------------------------------------------------------
// escape_time_checker
// Watches the register port and both word channels of the escape-time pixel
// evaluator. Each accepted pixel word is run through an independent
// fixed-point escape-time predictor using a shadow copy of the registers.
// Each accepted result word is compared field by field with the oldest
// prediction. Hands the failure count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module escape_time_checker #(
    parameter int FRAC_BITS        = 28,
    parameter int PIXEL_INDEX_BITS = 12,
    parameter int PALETTE_DEPTH    = 768
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [metp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [metp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [PIXEL_INDEX_BITS-1:0]         s_pixel_column,
    input  logic [PIXEL_INDEX_BITS-1:0]         s_pixel_row,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [metp_pkg::ITER_W-1:0]         m_iteration_count,
    input  logic                                m_escaped,
    input  logic [metp_pkg::PAL_W-1:0]          m_palette_index,
    input  logic [metp_pkg::COLOUR_W-1:0]       m_red,
    input  logic [metp_pkg::COLOUR_W-1:0]       m_green,
    input  logic [metp_pkg::COLOUR_W-1:0]       m_blue,
    output int                                  fail_count,
    output int                                  pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    import metp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ITER_W-1:0]   count;
        logic                escaped;
        logic [PAL_W-1:0]    index;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } pixel_result_t;

    // Shadow registers
    coord_t              x_start_r;
    coord_t              x_step_r;
    coord_t              y_start_r;
    coord_t              y_step_r;
    coord_t              z_re0_r;
    coord_t              z_im0_r;
    logic [ITER_W-1:0]   iter_limit_r;
    logic [PAL_W-1:0]    pal_size_r;

    pixel_result_t       predicted_pixels[$];
    pixel_result_t       seen;
    pixel_result_t       want;
    int                  failures = 0;

    initial fail_count = 0;
    initial pending_words = 0;

    // Clamp to the signed 32-bit coordinate range
    function automatic longint clamp_coord(input longint v);
        if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
        if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
        return v;
    endfunction

    // Escape-time evaluation of one pixel under the shadow registers
    function automatic pixel_result_t escape_time_of(
        input logic [PIXEL_INDEX_BITS-1:0] col,
        input logic [PIXEL_INDEX_BITS-1:0] row
    );
        longint        cr;
        longint        ci;
        longint        zr;
        longint        zi;
        longint        rr;
        longint        ii;
        longint        nr;
        longint        ni;
        logic [63:0]   mag2;
        int unsigned   count;
        int unsigned   psize;
        int unsigned   idx;
        pixel_result_t res;

        cr = clamp_coord(longint'(x_start_r) + longint'(col) * longint'(x_step_r));
        ci = clamp_coord(longint'(y_start_r) + longint'(row) * longint'(y_step_r));
        zr = longint'(z_re0_r);
        zi = longint'(z_im0_r);
        count = 0;
        idx = 0;

        while (count < iter_limit_r) begin
            rr = zr * zr;
            ii = zi * zi;
            // sum of squares can reach 2^63, so test it unsigned
            mag2 = rr + ii;
            if ((mag2 >> FRAC_BITS) >= (64'd4 << FRAC_BITS)) break;
            count++;
            nr = clamp_coord(((rr - ii) >>> FRAC_BITS) + cr);
            ni = clamp_coord(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
            zr = nr;
            zi = ni;
        end

        res = '0;
        res.count = count[ITER_W-1:0];
        res.escaped = (count < iter_limit_r);
        if (res.escaped) begin
            psize = pal_size_r;
            if (psize == 0) psize = 1;
            if (psize > PALETTE_DEPTH) psize = PALETTE_DEPTH;
            idx = count % psize;
            res.index = idx[PAL_W-1:0];
            res.red = (idx > RED_BASE) ? COLOUR_W'(idx - RED_BASE) : '0;
            if (idx < GREEN_BASE) res.green = '0;
            else if (idx > GREEN_TOP) res.green = COLOUR_MAX;
            else res.green = COLOUR_W'(idx - GREEN_BASE);
            res.blue = (idx > BLUE_TOP) ? COLOUR_MAX : COLOUR_W'(idx);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            x_start_r    = RST_X_START;
            x_step_r     = RST_X_STEP;
            y_start_r    = RST_Y_START;
            y_step_r     = RST_Y_STEP;
            z_re0_r      = RST_Z_INIT_RE;
            z_im0_r      = RST_Z_INIT_IM;
            iter_limit_r = RST_ITER_LIM;
            pal_size_r   = RST_PAL_SIZE;
            predicted_pixels.delete();
        end else begin
            // result word against the oldest prediction
            if (m_valid && m_ready) begin
                seen.count   = m_iteration_count;
                seen.escaped = m_escaped;
                seen.index   = m_palette_index;
                seen.red     = m_red;
                seen.green   = m_green;
                seen.blue    = m_blue;
                if (predicted_pixels.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: result word with no pixel outstanding: count %0d esc %0d",
                                 $realtime, seen.count, seen.escaped);
                end else begin
                    want = predicted_pixels.pop_front();
                    if (seen !== want) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected count %0d esc %0d idx %0d rgb %0d/%0d/%0d",
                                     want.count, want.escaped, want.index,
                                     want.red, want.green, want.blue);
                            $display("  got      count %0d esc %0d idx %0d rgb %0d/%0d/%0d",
                                     seen.count, seen.escaped, seen.index,
                                     seen.red, seen.green, seen.blue);
                        end
                    end
                end
            end

            // pixel word uses the registers in force before this edge
            if (s_valid && s_ready)
                predicted_pixels.push_back(escape_time_of(s_pixel_column, s_pixel_row));

            if (cfg_we) begin
                case (cfg_addr)
                    REG_X_START:   x_start_r    = coord_t'(cfg_wdata);
                    REG_X_STEP:    x_step_r     = coord_t'(cfg_wdata);
                    REG_Y_START:   y_start_r    = coord_t'(cfg_wdata);
                    REG_Y_STEP:    y_step_r     = coord_t'(cfg_wdata);
                    REG_Z_INIT_RE: z_re0_r      = coord_t'(cfg_wdata);
                    REG_Z_INIT_IM: z_im0_r      = coord_t'(cfg_wdata);
                    REG_ITER_LIM:  iter_limit_r = cfg_wdata[ITER_W-1:0];
                    REG_PAL_SIZE:  pal_size_r   = cfg_wdata[PAL_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count    <= failures;
        pending_words <= predicted_pixels.size();
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the escape-time pixel evaluator. A directed part
// covers the register extremes and the corner cases (saturated c, start
// outside the radius, zero limit, palette size of zero and above the depth,
// the longest possible iteration run), then batches of random pixel words
// under random views of the plane, with random idling on both channels.
// Prediction and comparison live in escape_time_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import metp_pkg::*;

    localparam int PIX_W        = 12;
    localparam int STALL_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 50;
    localparam int BATCHES      = 10;
    localparam int BATCH_WORDS  = 25;

    // Q4.28 points of interest
    localparam coord_t CUSP_RE   = 32'sd67108864;   // 0.25
    localparam coord_t CUSP_STEP = 32'sd268;        // about 1e-6 per column

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [PIX_W-1:0]         s_pixel_column = '0;
    logic [PIX_W-1:0]         s_pixel_row = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [ITER_W-1:0]        m_iteration_count;
    logic                     m_escaped;
    logic [PAL_W-1:0]         m_palette_index;
    logic [COLOUR_W-1:0]      m_red;
    logic [COLOUR_W-1:0]      m_green;
    logic [COLOUR_W-1:0]      m_blue;

    int fail_count;
    int pending_words;
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    mandelbrot_escape_time_pixel DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_column    (s_pixel_column),
        .s_pixel_row       (s_pixel_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_escaped         (m_escaped),
        .m_palette_index   (m_palette_index),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue)
    );

    escape_time_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel_column    (s_pixel_column),
        .s_pixel_row       (s_pixel_row),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_escaped         (m_escaped),
        .m_palette_index   (m_palette_index),
        .m_red             (m_red),
        .m_green           (m_green),
        .m_blue            (m_blue),
        .fail_count        (fail_count),
        .pending_words     (pending_words)
    );

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: cycles without any word moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One pixel word, with a random idle run in front of it
    task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_pixel_column <= col;
        s_pixel_row    <= row;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Rewrite the whole register set once the block is idle
    task automatic load_view(input cfg_t v);
        wait_results();
        put_reg(REG_X_START,   v.x_start);
        put_reg(REG_X_STEP,    v.x_step);
        put_reg(REG_Y_START,   v.y_start);
        put_reg(REG_Y_STEP,    v.y_step);
        put_reg(REG_Z_INIT_RE, v.z_init_re);
        put_reg(REG_Z_INIT_IM, v.z_init_im);
        // junk in the unused upper bits
        put_reg(REG_ITER_LIM,  ($urandom & 32'hFFFF_0000) | 32'(v.iteration_limit));
        put_reg(REG_PAL_SIZE,  ($urandom & 32'hFFFF_FC00) | 32'(v.palette_size));
        cfg_we <= 1'b0;
    endtask

    // Mostly a window over the interesting part of the plane, small limits
    function automatic cfg_t random_view();
        cfg_t v;
        int   kind;

        kind = $urandom_range(9);
        v.x_start   = coord_t'(int'($urandom_range(671088640)) - 671088640);
        v.x_step    = coord_t'($urandom_range(196608));
        if ($urandom_range(3) == 0) v.x_step = -v.x_step;
        v.y_start   = coord_t'(int'($urandom_range(402653184)) - 402653184);
        v.y_step    = coord_t'($urandom_range(196608));
        if ($urandom_range(3) == 0) v.y_step = -v.y_step;
        v.z_init_re = '0;
        v.z_init_im = '0;
        if (kind < 2) begin
            v.z_init_re = coord_t'(int'($urandom_range(268435456)) - 134217728);
            v.z_init_im = coord_t'(int'($urandom_range(268435456)) - 134217728);
        end else if (kind == 2) begin
            // anywhere at all: heavy saturation
            v.x_start   = coord_t'($urandom);
            v.x_step    = coord_t'($urandom);
            v.y_start   = coord_t'($urandom);
            v.y_step    = coord_t'($urandom);
            v.z_init_re = coord_t'($urandom);
            v.z_init_im = coord_t'($urandom);
        end
        if ($urandom_range(9) == 0)
            v.iteration_limit = ITER_W'($urandom_range(300, 100));
        else
            v.iteration_limit = ITER_W'($urandom_range(48, 1));
        if ($urandom_range(1) == 0)
            v.palette_size = PAL_W'($urandom_range(16));
        else
            v.palette_size = PAL_W'($urandom_range(1023));
        return v;
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        sender_idle_pct = 34;
        recv_idle_pct   = 69;
        @(posedge aclk);

        // reset view: corners, c saturating at the far columns, c near 0 inside
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd800, 12'd400);
        send_pixel(12'd2048, 12'd2048);

        // just right of the cusp: long escape runs, red end of the ramp
        load_view(cfg_t'{CUSP_RE, CUSP_STEP, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                         16'd768, 10'd768});
        send_pixel(12'd12, PIX_W'($urandom_range(4095)));
        send_pixel(12'd17, PIX_W'($urandom_range(4095)));
        send_pixel(12'd22, PIX_W'($urandom_range(4095)));
        send_pixel(12'd30, PIX_W'($urandom_range(4095)));
        send_pixel(12'd40, PIX_W'($urandom_range(4095)));
        send_pixel(12'd4095, PIX_W'($urandom_range(4095)));

        // start already outside the radius, palette size of zero
        load_view(cfg_t'{RST_X_START, RST_X_STEP, RST_Y_START, RST_Y_STEP,
                         COORD_MAX, COORD_MIN, 16'd5, 10'd0});
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);

        // zero iteration limit, oversized palette
        load_view(cfg_t'{RST_X_START, RST_X_STEP, RST_Y_START, RST_Y_STEP,
                         32'sd0, 32'sd0, 16'd0, 10'd1023});
        send_pixel(12'd100, 12'd200);
        send_pixel(12'd4095, 12'd4095);

        // counts beyond the palette depth
        load_view(cfg_t'{CUSP_RE, CUSP_STEP, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                         16'd2000, 10'd1023});
        send_pixel(12'd3, 12'd0);
        send_pixel(12'd5, 12'd0);
        send_pixel(12'd8, 12'd0);

        // longest possible run: c = 0 at the largest limit
        load_view(cfg_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                         16'hFFFF, 10'd768});
        send_pixel(12'd7, 12'd9);

        // random batches; every view change drains the block first
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                sender_idle_pct = 69;
                recv_idle_pct   = 34;
            end else if (phase == 2) begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            for (int batch = 0; batch < BATCHES; batch++) begin
                load_view(random_view());
                repeat (BATCH_WORDS)
                    send_pixel(PIX_W'($urandom_range(4095)), PIX_W'($urandom_range(4095)));
            end
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_words == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
